// ===== src/mqf_pkg.sv =====
package mqf_pkg;

    localparam int QUEUES   = 24;
    localparam int CAPACITY = 64;
    localparam int ID_BITS  = 16;
    localparam int PTR_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int QIDX_W   = 5;

    localparam logic [1:0] ACT_ADD  = 2'd0;
    localparam logic [1:0] ACT_RIDE = 2'd1;
    localparam logic [1:0] ACT_LIST = 2'd2;
    localparam logic [1:0] ACT_NOP  = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;
    localparam logic [1:0] ST_FULL  = 2'd3;

    typedef struct packed {
        logic [1:0]  action;
        logic [4:0]  queue_index;
        logic [15:0] visitor_id;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] result_id;
        logic        last_of_run;
    } out_item_t;

    // Classified command passed from front to back
    typedef struct packed {
        logic [1:0]        action;
        logic              range_err;
        logic [QIDX_W-1:0] queue_index;
        logic [15:0]       visitor_id;
    } cmd_t;

endpackage

// ===== src/multi_queue_fifo_manager.sv =====
// A list streams the queue's ids from the head, one id a cycle while pop keeps up.
// Commands are taken one at a time, paced by the single read port of the link
// and id memories; the front holds up to two waiting commands.
// Reset: asynchronous, active low; all queues empty, store unused.
module multi_queue_fifo_manager (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  mqf_pkg::in_item_t  in_item,
    output logic               empty,
    input  logic               pop,
    output mqf_pkg::out_item_t out_item
);
    import mqf_pkg::*;

    logic cmd_valid, cmd_take;
    cmd_t cmd;

    mqf_front u_front (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .in_item(in_item),
        .cmd_valid(cmd_valid), .cmd(cmd), .cmd_take(cmd_take));

    mqf_back u_back (
        .clk(clk), .rst_n(rst_n), .cmd_valid(cmd_valid), .cmd(cmd),
        .cmd_take(cmd_take), .empty(empty), .pop(pop), .out_item(out_item));

endmodule

// ===== src/mqf_ram.sv =====
module mqf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== src/mqf_front.sv =====
module mqf_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    output logic            full,
    input  mqf_pkg::in_item_t in_item,
    output logic            cmd_valid,
    output mqf_pkg::cmd_t   cmd,
    input  logic            cmd_take
);
    import mqf_pkg::*;

    // Two-entry command queue between front and back
    cmd_t       buf_reg [2];
    logic       rd_reg, rd_next, wr_reg, wr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       accept;
    cmd_t       c;

    assign full      = (cnt_reg == 2'd2);
    assign accept    = push && !full && (in_item.action != ACT_NOP);
    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd       = buf_reg[rd_reg];

    always_comb
    begin
        c.action      = in_item.action;
        c.range_err   = (32'(in_item.queue_index) >= QUEUES);
        c.queue_index = in_item.queue_index;
        c.visitor_id  = in_item.visitor_id & 16'((64'd1 << ID_BITS) - 64'd1);
        wr_next  = accept ? ~wr_reg : wr_reg;
        rd_next  = cmd_take ? ~rd_reg : rd_reg;
        cnt_next = cnt_reg + {1'b0, accept} - {1'b0, cmd_take};
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            buf_reg[wr_reg] <= c;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_reg  <= 1'b0;
            wr_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            rd_reg  <= rd_next;
            wr_reg  <= wr_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

// ===== src/mqf_back.sv =====
module mqf_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    input  mqf_pkg::cmd_t      cmd,
    output logic               cmd_take,
    output logic               empty,
    input  logic               pop,
    output mqf_pkg::out_item_t out_item
);
    import mqf_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_EMIT = 2'd2;

    logic [1:0]       state_reg, state_next;
    cmd_t             cur_reg, cur_next;
    logic [PTR_W-1:0] head_reg [QUEUES];
    logic [PTR_W-1:0] tail_reg [QUEUES];
    logic [CNT_W-1:0] qcnt_reg [QUEUES];
    logic [PTR_W-1:0] free_head_reg, free_head_next;
    logic [CNT_W-1:0] freed_reg, freed_next;
    logic [CNT_W-1:0] fresh_reg, fresh_next;
    logic [CNT_W-1:0] left_reg, left_next;
    logic [PTR_W-1:0] slot_reg, slot_next;
    logic             ovalid_reg, ovalid_next;
    out_item_t        out_reg, out_next;

    logic             link_we, id_we;
    logic [PTR_W-1:0] link_waddr, link_wdata, id_waddr, rd_addr;
    logic [PTR_W-1:0] link_rdata;
    logic [15:0]      id_rdata;

    logic             q_we;
    logic [PTR_W-1:0] q_head_w, q_tail_w;
    logic [CNT_W-1:0] q_cnt_w;
    logic [QIDX_W-1:0] q;
    logic             out_free;

    assign q        = cur_reg.queue_index;
    assign empty    = !ovalid_reg;
    assign out_item = out_reg;
    assign out_free = !ovalid_reg || pop;

    mqf_ram #(.WIDTH(PTR_W), .DEPTH(CAPACITY)) u_link (
        .clk(clk), .we(link_we), .waddr(link_waddr), .wdata(link_wdata),
        .raddr(rd_addr), .rdata(link_rdata));

    mqf_ram #(.WIDTH(16), .DEPTH(CAPACITY)) u_id (
        .clk(clk), .we(id_we), .waddr(id_waddr), .wdata(cur_reg.visitor_id),
        .raddr(rd_addr), .rdata(id_rdata));

    always_comb
    begin
        state_next     = state_reg;
        cur_next       = cur_reg;
        free_head_next = free_head_reg;
        freed_next     = freed_reg;
        fresh_next     = fresh_reg;
        left_next      = left_reg;
        slot_next      = slot_reg;
        ovalid_next    = ovalid_reg && !pop;
        out_next       = out_reg;
        cmd_take       = 1'b0;
        link_we        = 1'b0;
        link_waddr     = slot_reg;
        link_wdata     = free_head_reg;
        id_we          = 1'b0;
        id_waddr       = slot_reg;
        rd_addr        = slot_reg;
        q_we           = 1'b0;
        q_head_w       = head_reg[q];
        q_tail_w       = tail_reg[q];
        q_cnt_w        = qcnt_reg[q];

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_take   = 1'b1;
                    cur_next   = cmd;
                    state_next = S_READ;
                    // fetch free-list link ahead of a possible add
                    rd_addr    = free_head_reg;
                end
            end
            S_READ:
            begin
                // hold the free-list link read while the output is blocked
                rd_addr = free_head_reg;
                if (out_free)
                begin
                    ovalid_next          = 1'b1;
                    out_next.result_id   = '0;
                    out_next.last_of_run = 1'b1;
                    state_next           = S_IDLE;
                    if (cur_reg.range_err)
                    begin
                        out_next.status = ST_RANGE;
                    end
                    else if (cur_reg.action == ACT_ADD)
                    begin
                        if (freed_reg != '0 || fresh_reg < CNT_W'(CAPACITY))
                        begin
                            out_next.status = ST_OK;
                            if (freed_reg != '0)
                            begin
                                id_waddr       = free_head_reg;
                                free_head_next = link_rdata;
                                freed_next     = freed_reg - CNT_W'(1);
                            end
                            else
                            begin
                                id_waddr   = fresh_reg[PTR_W-1:0];
                                fresh_next = fresh_reg + CNT_W'(1);
                            end
                            id_we = 1'b1;
                            q_we  = 1'b1;
                            if (qcnt_reg[q] == '0)
                            begin
                                q_head_w = id_waddr;
                            end
                            else
                            begin
                                link_we    = 1'b1;
                                link_waddr = tail_reg[q];
                                link_wdata = id_waddr;
                            end
                            q_tail_w = id_waddr;
                            q_cnt_w  = qcnt_reg[q] + CNT_W'(1);
                        end
                        else
                        begin
                            out_next.status = ST_FULL;
                        end
                    end
                    else if (qcnt_reg[q] == '0)
                    begin
                        out_next.status = ST_EMPTY;
                    end
                    else
                    begin
                        // ride or list: start a chain read at the head
                        ovalid_next = ovalid_reg && !pop;
                        rd_addr     = head_reg[q];
                        slot_next   = head_reg[q];
                        left_next   = qcnt_reg[q];
                        state_next  = S_EMIT;
                    end
                end
            end
            S_EMIT:
            begin
                rd_addr = slot_reg;
                if (out_free)
                begin
                    ovalid_next          = 1'b1;
                    out_next.status      = ST_OK;
                    out_next.result_id   = id_rdata;
                    if (cur_reg.action == ACT_RIDE)
                    begin
                        out_next.last_of_run = 1'b1;
                        q_we    = 1'b1;
                        q_cnt_w = qcnt_reg[q] - CNT_W'(1);
                        if (qcnt_reg[q] == CNT_W'(1))
                        begin
                            q_head_w = '0;
                            q_tail_w = '0;
                        end
                        else
                        begin
                            q_head_w = link_rdata;
                        end
                        link_we        = 1'b1;
                        link_waddr     = slot_reg;
                        link_wdata     = free_head_reg;
                        free_head_next = slot_reg;
                        freed_next     = freed_reg + CNT_W'(1);
                        state_next     = S_IDLE;
                    end
                    else
                    begin
                        out_next.last_of_run = (left_reg == CNT_W'(1));
                        left_next = left_reg - CNT_W'(1);
                        slot_next = link_rdata;
                        rd_addr   = link_rdata;
                        if (left_reg == CNT_W'(1))
                        begin
                            state_next = S_IDLE;
                        end
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
        cur_reg <= cur_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            free_head_reg <= '0;
            freed_reg     <= '0;
            fresh_reg     <= '0;
            left_reg      <= '0;
            slot_reg      <= '0;
            ovalid_reg    <= 1'b0;
            for (int i = 0; i < QUEUES; i++)
            begin
                head_reg[i] <= '0;
                tail_reg[i] <= '0;
                qcnt_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            free_head_reg <= free_head_next;
            freed_reg     <= freed_next;
            fresh_reg     <= fresh_next;
            left_reg      <= left_next;
            slot_reg      <= slot_next;
            ovalid_reg    <= ovalid_next;
            if (q_we)
            begin
                head_reg[q] <= q_head_w;
                tail_reg[q] <= q_tail_w;
                qcnt_reg[q] <= q_cnt_w;
            end
        end
    end

endmodule

// ===== sim/mqf_checker.sv =====
`timescale 1ns / 1ps

module mqf_checker
    import mqf_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  logic      full,
    input  in_item_t  in_item,
    input  logic      empty,
    input  logic      pop,
    input  out_item_t out_item,
    output int        fail_count,
    output int        pending,
    output int        results_seen
);

    logic [PTR_W-1:0] head_q [QUEUES];
    logic [PTR_W-1:0] tail_q [QUEUES];
    int               depth_q [QUEUES];
    logic [PTR_W-1:0] link_mem [CAPACITY];
    logic [15:0]      id_mem [CAPACITY];
    logic [PTR_W-1:0] free_top;
    int               free_cnt;
    int               fresh_cnt;
    out_item_t        expected_q [$];

    function automatic out_item_t mk(logic [1:0] st, logic [15:0] id, logic last);
        out_item_t r;
        r.status      = st;
        r.result_id   = id;
        r.last_of_run = last;
        return r;
    endfunction

    task automatic predict_queue_op(input in_item_t it);
        int               q;
        int               n;
        logic [PTR_W-1:0] slot;
        q = it.queue_index;
        if (it.action == ACT_NOP)
            return;
        if (q >= QUEUES)
        begin
            expected_q.push_back(mk(ST_RANGE, '0, 1'b1));
            return;
        end
        if (it.action == ACT_ADD)
        begin
            if (free_cnt > 0)
            begin
                slot = free_top;
                free_top = link_mem[slot];
                free_cnt--;
            end
            else if (fresh_cnt < CAPACITY)
            begin
                slot = PTR_W'(fresh_cnt);
                fresh_cnt++;
            end
            else
            begin
                expected_q.push_back(mk(ST_FULL, '0, 1'b1));
                return;
            end
            id_mem[slot] = it.visitor_id;
            if (depth_q[q] == 0)
                head_q[q] = slot;
            else
                link_mem[tail_q[q]] = slot;
            tail_q[q] = slot;
            depth_q[q]++;
            expected_q.push_back(mk(ST_OK, '0, 1'b1));
            return;
        end
        if (depth_q[q] == 0)
        begin
            expected_q.push_back(mk(ST_EMPTY, '0, 1'b1));
            return;
        end
        if (it.action == ACT_RIDE)
        begin
            slot = head_q[q];
            expected_q.push_back(mk(ST_OK, id_mem[slot], 1'b1));
            depth_q[q]--;
            if (depth_q[q] == 0)
            begin
                head_q[q] = '0;
                tail_q[q] = '0;
            end
            else
                head_q[q] = link_mem[slot];
            link_mem[slot] = free_top;
            free_top = slot;
            free_cnt++;
            return;
        end
        n = depth_q[q];
        slot = head_q[q];
        for (int k = 0; k < n; k++)
        begin
            expected_q.push_back(mk(ST_OK, id_mem[slot], k == n - 1));
            slot = link_mem[slot];
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        out_item_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < QUEUES; i++)
            begin
                head_q[i]  = '0;
                tail_q[i]  = '0;
                depth_q[i] = 0;
            end
            for (int i = 0; i < CAPACITY; i++)
            begin
                link_mem[i] = '0;
                id_mem[i]   = '0;
            end
            free_top     = '0;
            free_cnt     = 0;
            fresh_cnt    = 0;
            fail_count   = 0;
            results_seen = 0;
            expected_q.delete();
        end
        else
        begin
            if (pop && !empty)
            begin
                results_seen++;
                if (expected_q.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result st=%0d id=%h last=%0b",
                                 out_item.status, out_item.result_id,
                                 out_item.last_of_run);
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (out_item.status !== want.status
                        || out_item.result_id !== want.result_id
                        || out_item.last_of_run !== want.last_of_run)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("mismatch exp %0d/%h/%0b got %0d/%h/%0b",
                                     want.status, want.result_id, want.last_of_run,
                                     out_item.status, out_item.result_id,
                                     out_item.last_of_run);
                    end
                end
            end
            if (push && !full)
                predict_queue_op(in_item);
        end
        pending = expected_q.size();
    end

endmodule

// ===== sim/tb_multi_queue_fifo_manager.sv =====
`timescale 1ns / 1ps

module tb_multi_queue_fifo_manager;
    import mqf_pkg::*;

    localparam int STALL_LIMIT = 20000;
    localparam int HOLD_CYCLES = 300;

    logic      clk;
    logic      rst_n;
    logic      push;
    logic      full;
    in_item_t  in_item;
    logic      empty;
    logic      pop;
    out_item_t out_item;
    int        fail_count;
    int        pending;
    int        results_seen;
    int        items_sent;
    int        idle_cycles;
    bit        hold_req;

    multi_queue_fifo_manager u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (full),
        .in_item (in_item),
        .empty   (empty),
        .pop     (pop),
        .out_item(out_item)
    );

    mqf_checker u_chk (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .in_item     (in_item),
        .empty       (empty),
        .pop         (pop),
        .out_item    (out_item),
        .fail_count  (fail_count),
        .pending     (pending),
        .results_seen(results_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Offer one item and hold it until taken, optionally with a random gap first.
    // Push stays high after acceptance; the next call or the caller drops it.
    task automatic send_item(input logic [1:0] act, input logic [4:0] q,
                             input logic [15:0] id, input bit no_gap);
        int gap;
        gap = no_gap ? 0 : (($urandom_range(0, 3) == 0) ? $urandom_range(0, 16) : 0);
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push    <= 1'b1;
        in_item <= '{action: act, queue_index: q, visitor_id: id};
        do
            @(posedge clk);
        while (full);
        items_sent++;
    endtask

    // Receiver: random stalls per item, plus one long hold-off when asked.
    initial
    begin
        int wait_n;
        bit held;
        pop  = 1'b0;
        held = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_req && !held)
            begin
                held = 1'b1;
                pop <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                pop <= 1'b1;
            end
            else if (pop && !empty)
            begin
                wait_n = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 16) : 0;
                if (wait_n > 0)
                begin
                    pop <= 1'b0;
                    repeat (wait_n) @(posedge clk);
                end
                pop <= 1'b1;
            end
            else
                pop <= 1'b1;
        end
    end

    // Count cycles with no accepted traffic.
    always @(posedge clk)
    begin
        if (!rst_n || (push && !full) || (pop && !empty))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("watchdog: no progress, %0d results still due", pending);
            $display("multi_queue_fifo_manager verification failed");
            $finish;
        end
    end

    initial
    begin
        int r;
        logic [1:0] act;
        logic [4:0] q;
        push        = 1'b0;
        in_item     = '0;
        rst_n       = 1'b0;
        hold_req    = 1'b0;
        items_sent  = 0;
        idle_cycles = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty, range, fill, list, ride, ignored action.
        send_item(ACT_RIDE, 5'd0, 16'h0000, 1);
        send_item(ACT_LIST, 5'd23, 16'h0000, 1);
        send_item(ACT_ADD, 5'd24, 16'hFFFF, 1);
        send_item(ACT_RIDE, 5'd31, 16'h0000, 1);
        send_item(ACT_LIST, 5'd31, 16'hFFFF, 1);
        send_item(ACT_NOP, 5'd0, 16'h1234, 1);
        send_item(ACT_ADD, 5'd0, 16'hFFFF, 1);
        send_item(ACT_ADD, 5'd0, 16'h0000, 1);
        send_item(ACT_ADD, 5'd0, 16'hA5A5, 1);
        send_item(ACT_ADD, 5'd23, 16'h5A5A, 1);
        send_item(ACT_LIST, 5'd0, 16'h0000, 1);
        send_item(ACT_LIST, 5'd23, 16'h0000, 1);
        send_item(ACT_RIDE, 5'd0, 16'h0000, 1);
        send_item(ACT_RIDE, 5'd23, 16'h0000, 1);
        send_item(ACT_RIDE, 5'd23, 16'h0000, 1);
        send_item(ACT_ADD, 5'd1, 16'h8001, 1);
        send_item(ACT_LIST, 5'd1, 16'h0000, 1);

        // Fill the store while the receiver holds off, then list it all.
        hold_req <= 1'b1;
        for (int i = 0; i < 66; i++)
            send_item(ACT_ADD, 5'(i % 3), 16'($urandom), 1);
        for (int i = 0; i < 3; i++)
            send_item(ACT_LIST, 5'(i), 16'h0000, 0);
        for (int i = 0; i < 40; i++)
            send_item(ACT_RIDE, 5'(i % 3), 16'h0000, 0);

        // Random: mostly valid queues, adds and rides, some lists and noise.
        for (int i = 0; i < 300; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 45)
                act = ACT_ADD;
            else if (r < 85)
                act = ACT_RIDE;
            else if (r < 95)
                act = ACT_LIST;
            else
                act = ACT_NOP;
            q = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(24, 31))
                                             : 5'($urandom_range(0, 5));
            send_item(act, q, 16'($urandom), 0);
        end
        push <= 1'b0;

        while (pending != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        $display("run: %0d items offered, %0d results checked", items_sent, results_seen);
        $display("covered empty and bad queues, a full store and a long receiver stall");
        if (fail_count == 0)
            $display("multi_queue_fifo_manager verification clean");
        else
            $display("multi_queue_fifo_manager verification failed");
        $finish;
    end

endmodule

// ===== multi_queue_fifo_manager.f =====
src/mqf_pkg.sv
src/mqf_ram.sv
src/mqf_front.sv
src/mqf_back.sv
src/multi_queue_fifo_manager.sv
sim/mqf_checker.sv
sim/tb_multi_queue_fifo_manager.sv
